// ===== sv/cbf_pkg.sv =====
// Shared types, sizes and helpers for the cubic curve flattener.
package cbf_pkg;
   localparam int COORD_BITS = 13;
   localparam int MAX_DEPTH  = 6;
   localparam int COLOR_BITS = 8;
   localparam int LVL_BITS   = $clog2(MAX_DEPTH + 1);
   localparam int STK_IDX    = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
   localparam int DIFF_BITS  = COORD_BITS + 1;
   localparam int PROD_BITS  = 2 * DIFF_BITS;
   localparam int CROSS_BITS = PROD_BITS + 1;
   localparam int SQ_BITS    = 2 * CROSS_BITS;
   localparam int NEAR_LIMIT = 4;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef coord_type [3:0] quad_type;
   typedef logic [LVL_BITS-1:0] level_type;

   typedef struct packed {
      quad_type                x;
      quad_type                y;
      logic [COLOR_BITS-1:0]   color;
   } curve_type;

   // Midpoint with the halving truncated toward zero.
   function automatic coord_type mid(input coord_type a, input coord_type b);
      logic signed [COORD_BITS:0] s;
      s = {a[COORD_BITS-1], a} + {b[COORD_BITS-1], b};
      s = s + {{COORD_BITS{1'b0}}, s[COORD_BITS]};
      return s[COORD_BITS:1];
   endfunction
endpackage

// ===== sv/cbf_queue.sv =====
// Front end: two-entry curve queue between the request channel and the engine.
module cbf_queue import cbf_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_stall,
   input  curve_type in_curve,
   output logic      q_valid,
   input  logic      q_take,
   output curve_type q_curve
);
   curve_type  entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   logic       pop;

   assign in_stall = (count_ff == 2'd2);
   assign q_valid  = (count_ff != 2'd0);
   assign q_curve  = entry_ff[rd_ptr_ff];
   assign push     = in_valid && !in_stall;
   assign pop      = q_take && q_valid;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_curve;
      end
   end
endmodule

// ===== sv/cbf_engine.sv =====
// Back end: flatness test pipeline, midpoint split, right-half stack and segment output.
module cbf_engine import cbf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   output logic                  q_take,
   input  curve_type             q_curve,
   output logic                  out_valid,
   input  logic                  out_stall,
   output coord_type             out_x0,
   output coord_type             out_y0,
   output coord_type             out_x1,
   output coord_type             out_y1,
   output logic [COLOR_BITS-1:0] out_color,
   output logic                  out_last
);
   typedef enum logic [2:0] {
      S_IDLE, S_DIFF, S_PROD, S_SUM, S_SQ, S_DECIDE
   } state_type;

   typedef logic signed [DIFF_BITS-1:0]  diff_type;
   typedef logic signed [PROD_BITS-1:0]  prod_type;
   typedef logic signed [CROSS_BITS-1:0] cross_type;
   typedef logic signed [SQ_BITS-1:0]    sq_type;

   state_type state_ff, state_in;
   quad_type  cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   level_type level_ff, level_in;
   level_type sp_ff, sp_in;
   logic [COLOR_BITS-1:0] color_ff, color_in;

   quad_type  stk_x_ff [MAX_DEPTH];
   quad_type  stk_y_ff [MAX_DEPTH];
   level_type stk_l_ff [MAX_DEPTH];

   diff_type  dx_ff, dy_ff, ex1_ff, ey1_ff, ex2_ff, ey2_ff;
   prod_type  p_dxdx_ff, p_dydy_ff, p_dxey1_ff, p_dyex1_ff, p_dxey2_ff, p_dyex2_ff;
   prod_type  p_ex1_ff, p_ey1_ff, p_ex2_ff, p_ey2_ff;
   cross_type len2_ff, c1_ff, c2_ff, z1_ff, z2_ff;
   sq_type    c1sq_ff, c2sq_ff, len2w_ff;
   logic      zero_ff, near_ff;

   logic      ov_ff, ov_in;
   coord_type ox0_ff, ox0_in, oy0_ff, oy0_in, ox1_ff, ox1_in, oy1_ff, oy1_in;
   logic [COLOR_BITS-1:0] ocol_ff, ocol_in;
   logic      olast_ff, olast_in;

   quad_type  lx, ly, rx, ry;
   logic      flat, stop, out_free, push;
   level_type top_idx;

   assign out_valid = ov_ff;
   assign out_x0    = ox0_ff;
   assign out_y0    = oy0_ff;
   assign out_x1    = ox1_ff;
   assign out_y1    = oy1_ff;
   assign out_color = ocol_ff;
   assign out_last  = olast_ff;
   assign q_take    = (state_ff == S_IDLE) && q_valid;

   // de Casteljau halves of the current piece.
   always_comb begin
      coord_type m01x, m12x, m23x, m012x, m123x, mx;
      coord_type m01y, m12y, m23y, m012y, m123y, my;
      m01x  = mid(cur_x_ff[0], cur_x_ff[1]);
      m12x  = mid(cur_x_ff[1], cur_x_ff[2]);
      m23x  = mid(cur_x_ff[2], cur_x_ff[3]);
      m012x = mid(m01x, m12x);
      m123x = mid(m12x, m23x);
      mx    = mid(m012x, m123x);
      m01y  = mid(cur_y_ff[0], cur_y_ff[1]);
      m12y  = mid(cur_y_ff[1], cur_y_ff[2]);
      m23y  = mid(cur_y_ff[2], cur_y_ff[3]);
      m012y = mid(m01y, m12y);
      m123y = mid(m12y, m23y);
      my    = mid(m012y, m123y);
      lx = {mx, m012x, m01x, cur_x_ff[0]};
      ly = {my, m012y, m01y, cur_y_ff[0]};
      rx = {cur_x_ff[3], m23x, m123x, mx};
      ry = {cur_y_ff[3], m23y, m123y, my};
   end

   assign flat = zero_ff ? near_ff : ((c1sq_ff <= len2w_ff) && (c2sq_ff <= len2w_ff));
   assign stop = (level_ff >= level_type'(MAX_DEPTH)) || flat;
   assign out_free = !ov_ff || !out_stall;
   assign top_idx = sp_ff - level_type'(1);
   assign push = (state_ff == S_DECIDE) && !stop;

   always_comb begin
      state_in = state_ff;
      cur_x_in = cur_x_ff;
      cur_y_in = cur_y_ff;
      level_in = level_ff;
      sp_in    = sp_ff;
      color_in = color_ff;
      ov_in    = ov_ff && out_stall;
      ox0_in   = ox0_ff;
      oy0_in   = oy0_ff;
      ox1_in   = ox1_ff;
      oy1_in   = oy1_ff;
      ocol_in  = ocol_ff;
      olast_in = olast_ff;
      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               cur_x_in = q_curve.x;
               cur_y_in = q_curve.y;
               color_in = q_curve.color;
               level_in = '0;
               sp_in    = '0;
               state_in = S_DIFF;
            end
         end
         S_DIFF:  state_in = S_PROD;
         S_PROD:  state_in = S_SUM;
         S_SUM:   state_in = S_SQ;
         S_SQ:    state_in = S_DECIDE;
         S_DECIDE: begin
            if (!stop) begin
               cur_x_in = lx;
               cur_y_in = ly;
               level_in = level_ff + level_type'(1);
               sp_in    = sp_ff + level_type'(1);
               state_in = S_DIFF;
            end else if (out_free) begin
               ov_in    = 1'b1;
               ox0_in   = cur_x_ff[0];
               oy0_in   = cur_y_ff[0];
               ox1_in   = cur_x_ff[3];
               oy1_in   = cur_y_ff[3];
               ocol_in  = color_ff;
               olast_in = (sp_ff == '0);
               if (sp_ff == '0) begin
                  state_in = S_IDLE;
               end else begin
                  sp_in    = top_idx;
                  cur_x_in = stk_x_ff[top_idx[STK_IDX-1:0]];
                  cur_y_in = stk_y_ff[top_idx[STK_IDX-1:0]];
                  level_in = stk_l_ff[top_idx[STK_IDX-1:0]];
                  state_in = S_DIFF;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         sp_ff    <= '0;
         level_ff <= '0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         sp_ff    <= sp_in;
         level_ff <= level_in;
         ov_ff    <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_x_ff <= cur_x_in;
      cur_y_ff <= cur_y_in;
      color_ff <= color_in;
      ox0_ff   <= ox0_in;
      oy0_ff   <= oy0_in;
      ox1_ff   <= ox1_in;
      oy1_ff   <= oy1_in;
      ocol_ff  <= ocol_in;
      olast_ff <= olast_in;
      if (push) begin
         stk_x_ff[sp_ff[STK_IDX-1:0]] <= rx;
         stk_y_ff[sp_ff[STK_IDX-1:0]] <= ry;
         stk_l_ff[sp_ff[STK_IDX-1:0]] <= level_ff + level_type'(1);
      end
   end

   // Flatness pipeline: differences, products, sums, squares.
   always_ff @(posedge clock) begin
      dx_ff  <= DIFF_BITS'(cur_x_ff[3]) - DIFF_BITS'(cur_x_ff[0]);
      dy_ff  <= DIFF_BITS'(cur_y_ff[3]) - DIFF_BITS'(cur_y_ff[0]);
      ex1_ff <= DIFF_BITS'(cur_x_ff[1]) - DIFF_BITS'(cur_x_ff[0]);
      ey1_ff <= DIFF_BITS'(cur_y_ff[1]) - DIFF_BITS'(cur_y_ff[0]);
      ex2_ff <= DIFF_BITS'(cur_x_ff[2]) - DIFF_BITS'(cur_x_ff[0]);
      ey2_ff <= DIFF_BITS'(cur_y_ff[2]) - DIFF_BITS'(cur_y_ff[0]);

      p_dxdx_ff  <= dx_ff * dx_ff;
      p_dydy_ff  <= dy_ff * dy_ff;
      p_dxey1_ff <= dx_ff * ey1_ff;
      p_dyex1_ff <= dy_ff * ex1_ff;
      p_dxey2_ff <= dx_ff * ey2_ff;
      p_dyex2_ff <= dy_ff * ex2_ff;
      p_ex1_ff   <= ex1_ff * ex1_ff;
      p_ey1_ff   <= ey1_ff * ey1_ff;
      p_ex2_ff   <= ex2_ff * ex2_ff;
      p_ey2_ff   <= ey2_ff * ey2_ff;

      len2_ff <= CROSS_BITS'(p_dxdx_ff) + CROSS_BITS'(p_dydy_ff);
      c1_ff   <= CROSS_BITS'(p_dxey1_ff) - CROSS_BITS'(p_dyex1_ff);
      c2_ff   <= CROSS_BITS'(p_dxey2_ff) - CROSS_BITS'(p_dyex2_ff);
      z1_ff   <= CROSS_BITS'(p_ex1_ff) + CROSS_BITS'(p_ey1_ff);
      z2_ff   <= CROSS_BITS'(p_ex2_ff) + CROSS_BITS'(p_ey2_ff);

      c1sq_ff  <= c1_ff * c1_ff;
      c2sq_ff  <= c2_ff * c2_ff;
      len2w_ff <= SQ_BITS'(len2_ff);
      zero_ff  <= (len2_ff == '0);
      near_ff  <= (z1_ff <= CROSS_BITS'(NEAR_LIMIT)) && (z2_ff <= CROSS_BITS'(NEAR_LIMIT));
   end
endmodule

// ===== sv/cubic_bezier_flattener_core.sv =====
// Top level of the cubic curve flattener: request queue and subdivision engine.
//
// The req_ channel carries one cubic curve per transfer: four control points
// and a pen color. The rsp_ channel returns the line segments approximating
// the curve, in curve order, with rsp_seg_last set on the final one. Both
// channels use valid and stall; a transfer happens when valid is high and
// stall is low. A two-entry queue takes curves while the engine is busy, and
// req_stall rises only when that queue is full.
// Each piece of a curve passes through five engine steps (differences,
// products, sums, squares, decision), one piece at a time, and right
// halves wait on a single stack; a curve split to the full depth gives
// 64 segments. Segments wait in an output register while rsp_stall is
// high; the engine then holds at its decision step. Reset empties the
// queue and the output register and returns the engine to idle.
module cubic_bezier_flattener_core import cbf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  coord_type             req_start_x,
   input  coord_type             req_start_y,
   input  coord_type             req_ctrl1_x,
   input  coord_type             req_ctrl1_y,
   input  coord_type             req_ctrl2_x,
   input  coord_type             req_ctrl2_y,
   input  coord_type             req_end_x,
   input  coord_type             req_end_y,
   input  logic [COLOR_BITS-1:0] req_pen_color,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output coord_type             rsp_seg_x0,
   output coord_type             rsp_seg_y0,
   output coord_type             rsp_seg_x1,
   output coord_type             rsp_seg_y1,
   output logic [COLOR_BITS-1:0] rsp_seg_color,
   output logic                  rsp_seg_last
);
   curve_type in_curve;
   curve_type q_curve;
   logic      q_valid;
   logic      q_take;

   assign in_curve.x     = {req_end_x, req_ctrl2_x, req_ctrl1_x, req_start_x};
   assign in_curve.y     = {req_end_y, req_ctrl2_y, req_ctrl1_y, req_start_y};
   assign in_curve.color = req_pen_color;

   cbf_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_valid),
      .in_stall (req_stall),
      .in_curve (in_curve),
      .q_valid  (q_valid),
      .q_take   (q_take),
      .q_curve  (q_curve)
   );

   cbf_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_take    (q_take),
      .q_curve   (q_curve),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_x0    (rsp_seg_x0),
      .out_y0    (rsp_seg_y0),
      .out_x1    (rsp_seg_x1),
      .out_y1    (rsp_seg_y1),
      .out_color (rsp_seg_color),
      .out_last  (rsp_seg_last)
   );

   // A full queue always has a curve to offer the engine.
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> q_valid) else $error("request stalled with empty queue");

   // The engine only takes a curve that the queue offers.
   a_take_valid: assert property (@(posedge clock) disable iff (reset)
      q_take |-> q_valid) else $error("engine took from an empty queue");

   // Nothing is offered on the result channel right after reset.
   a_reset_out: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !rsp_valid) else $error("result valid after reset");
endmodule

// ===== test/cubic_bezier_flattener_core_test.sv =====
// Self-checking testbench for the cubic curve flattener core.
`timescale 1ns / 100ps

module cubic_bezier_flattener_core_test;
   import cbf_pkg::*;

   typedef struct {
      coord_type x0, y0, x1, y1;
      logic [COLOR_BITS-1:0] color;
      logic last;
   } segment_type;

   typedef struct {
      coord_type px[4];
      coord_type py[4];
      logic [COLOR_BITS-1:0] color;
   } curve_item_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   coord_type req_start_x = 0, req_start_y = 0, req_ctrl1_x = 0, req_ctrl1_y = 0;
   coord_type req_ctrl2_x = 0, req_ctrl2_y = 0, req_end_x = 0, req_end_y = 0;
   logic [COLOR_BITS-1:0] req_pen_color = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   coord_type rsp_seg_x0, rsp_seg_y0, rsp_seg_x1, rsp_seg_y1;
   logic [COLOR_BITS-1:0] rsp_seg_color;
   logic rsp_seg_last;

   cubic_bezier_flattener_core dut (.*);

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   curve_item_type pending_curves[$];
   segment_type expected_segments[$];
   int mismatches = 0;
   int curves_sent = 0;
   int segments_seen = 0;
   int idle_cycles = 0;
   bit drain_hold = 0;
   bit stim_done = 0;
   bit used_drain_hold = 0;

   function automatic coord_type half_sum(input int a, input int b);
      return coord_type'((a + b) / 2);
   endfunction

   function automatic bit is_flat(input int x[4], input int y[4]);
      longint dx, dy, len2, ex, ey, c;
      dx = x[3] - x[0];
      dy = y[3] - y[0];
      len2 = dx * dx + dy * dy;
      for (int i = 1; i <= 2; i++) begin
         ex = x[i] - x[0];
         ey = y[i] - y[0];
         if (len2 == 0) begin
            if (ex * ex + ey * ey > NEAR_LIMIT) return 0;
         end else begin
            c = dx * ey - dy * ex;
            if (c * c > len2) return 0;
         end
      end
      return 1;
   endfunction

   // Depth-first subdivision; right halves wait on a local stack.
   task automatic flatten_curve(input curve_item_type cv);
      int cx[4], cy[4], lvl, sp;
      int sx[MAX_DEPTH+1][4], sy[MAX_DEPTH+1][4], sl[MAX_DEPTH+1];
      int m01, m12, m23, m012, m123, mm;
      segment_type s;
      bit running;
      for (int i = 0; i < 4; i++) begin
         cx[i] = cv.px[i];
         cy[i] = cv.py[i];
      end
      lvl = 0;
      sp = 0;
      running = 1;
      while (running) begin
         if (lvl >= MAX_DEPTH || is_flat(cx, cy)) begin
            s.x0 = coord_type'(cx[0]);
            s.y0 = coord_type'(cy[0]);
            s.x1 = coord_type'(cx[3]);
            s.y1 = coord_type'(cy[3]);
            s.color = cv.color;
            s.last = (sp == 0);
            expected_segments.push_back(s);
            if (sp == 0) running = 0;
            else begin
               sp--;
               cx = sx[sp];
               cy = sy[sp];
               lvl = sl[sp];
            end
         end else begin
            for (int a = 0; a < 2; a++) begin
               int p[4];
               if (a != 0) p = cy;
               else p = cx;
               m01 = half_sum(p[0], p[1]);
               m12 = half_sum(p[1], p[2]);
               m23 = half_sum(p[2], p[3]);
               m012 = half_sum(m01, m12);
               m123 = half_sum(m12, m23);
               mm = half_sum(m012, m123);
               if (a != 0) begin
                  sy[sp] = '{mm, m123, m23, p[3]};
                  cy = '{p[0], m01, m012, mm};
               end else begin
                  sx[sp] = '{mm, m123, m23, p[3]};
                  cx = '{p[0], m01, m012, mm};
               end
            end
            lvl++;
            sl[sp] = lvl;
            sp++;
         end
      end
   endtask

   function automatic curve_item_type make_curve(input int v[8], input int color);
      curve_item_type c;
      for (int i = 0; i < 4; i++) begin
         c.px[i] = coord_type'(v[2*i]);
         c.py[i] = coord_type'(v[2*i+1]);
      end
      c.color = COLOR_BITS'(color);
      return c;
   endfunction

   function automatic int rand_coord(input int span);
      return $urandom_range(2 * span) - span;
   endfunction

   initial begin
      int v[8];
      int base_x, base_y, span;
      // Directed: extremes, degenerate, near-degenerate, straight, wild.
      v = '{default: 0};
      pending_curves.push_back(make_curve(v, 0));
      v = '{default: -4096};
      pending_curves.push_back(make_curve(v, 255));
      v = '{default: 4095};
      pending_curves.push_back(make_curve(v, 8'h55));
      v = '{0, 0, 2, 0, 0, 2, 0, 0};
      pending_curves.push_back(make_curve(v, 8'hAA));
      v = '{0, 0, 3, 0, 0, 0, 0, 0};
      pending_curves.push_back(make_curve(v, 1));
      v = '{-4096, -4096, -1365, -1365, 1365, 1365, 4095, 4095};
      pending_curves.push_back(make_curve(v, 2));
      v = '{-4096, -4096, 4095, -4096, -4096, 4095, 4095, 4095};
      pending_curves.push_back(make_curve(v, 3));
      v = '{-4096, 4095, 4095, 4095, 4095, -4096, -4096, -4096};
      pending_curves.push_back(make_curve(v, 4));
      v = '{4095, -4096, -4096, -4096, 4095, 4095, -4096, 4095};
      pending_curves.push_back(make_curve(v, 5));
      v = '{0, 0, 4095, 4095, -4096, -4096, 0, 0};
      pending_curves.push_back(make_curve(v, 6));
      v = '{-1, -1, 1, 1, -3, 3, 5, -5};
      pending_curves.push_back(make_curve(v, 7));
      v = '{-5, 0, -5, 9, 5, 9, 5, 0};
      pending_curves.push_back(make_curve(v, 128));
      for (int n = 0; n < 420; n++) begin
         // Mostly small or local curves, some full range.
         case ($urandom_range(3))
            0: span = 4096;
            1: span = 64;
            2: span = 8;
            default: span = $urandom_range(1024, 1);
         endcase
         base_x = rand_coord(4096 - span);
         base_y = rand_coord(4096 - span);
         for (int i = 0; i < 4; i++) begin
            v[2*i] = (span == 4096) ? $urandom_range(8191) - 4096
                                    : base_x + rand_coord(span - 1);
            v[2*i+1] = (span == 4096) ? $urandom_range(8191) - 4096
                                      : base_y + rand_coord(span - 1);
         end
         pending_curves.push_back(make_curve(v, $urandom_range(255)));
      end
      repeat (3) @(posedge clock);
      reset <= 0;
   end

   // Driver: random gap before most curves; one drain pause midway.
   int send_gap = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            flatten_curve(make_curve('{req_start_x, req_start_y, req_ctrl1_x, req_ctrl1_y,
               req_ctrl2_x, req_ctrl2_y, req_end_x, req_end_y}, req_pen_color));
            curves_sent++;
            send_gap = (curves_sent % 50 < 10) ? 0 : $urandom_range(12);
            if (curves_sent == 200) drain_hold = 1;
         end
         if (drain_hold && expected_segments.size() == 0) begin
            drain_hold = 0;
            used_drain_hold = 1;
         end
         if (!(req_valid && req_stall)) begin
            if (drain_hold || pending_curves.size() == 0) begin
               req_valid <= 0;
               if (pending_curves.size() == 0 && !drain_hold) stim_done = 1;
            end else if (send_gap > 0) begin
               send_gap--;
               req_valid <= 0;
            end else begin
               curve_item_type c;
               c = pending_curves.pop_front();
               req_valid <= 1;
               req_start_x <= c.px[0]; req_start_y <= c.py[0];
               req_ctrl1_x <= c.px[1]; req_ctrl1_y <= c.py[1];
               req_ctrl2_x <= c.px[2]; req_ctrl2_y <= c.py[2];
               req_end_x <= c.px[3]; req_end_y <= c.py[3];
               req_pen_color <= c.color;
            end
         end
      end
   end

   // Monitor: checks every segment transfer and draws the next stall.
   int stall_left = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            segment_type e;
            segments_seen++;
            if (expected_segments.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected segment %0d,%0d -> %0d,%0d",
                  rsp_seg_x0, rsp_seg_y0, rsp_seg_x1, rsp_seg_y1);
            end else begin
               e = expected_segments.pop_front();
               if (e.x0 !== rsp_seg_x0 || e.y0 !== rsp_seg_y0 || e.x1 !== rsp_seg_x1 ||
                   e.y1 !== rsp_seg_y1 || e.color !== rsp_seg_color ||
                   e.last !== rsp_seg_last) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"segment mismatch: expected %0d,%0d -> %0d,%0d c%0d l%0d, ",
                               "got %0d,%0d -> %0d,%0d c%0d l%0d"},
                        e.x0, e.y0, e.x1, e.y1, e.color, e.last, rsp_seg_x0, rsp_seg_y0,
                        rsp_seg_x1, rsp_seg_y1, rsp_seg_color, rsp_seg_last);
               end
            end
            stall_left = (segments_seen % 300 < 40) ? 0 : $urandom_range(12);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1;
         end else rsp_stall <= 0;
      end
   end

   // Watchdog and end of run.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= 20000) begin
         $display("cubic_bezier_flattener_core test failed");
         $finish;
      end
   end

   initial begin
      wait (stim_done && expected_segments.size() == 0);
      repeat (100) @(posedge clock);
      $display("Sent %0d curves, checked %0d segments, drain pause %0s.",
         curves_sent, segments_seen, used_drain_hold ? "done" : "missed");
      if (mismatches == 0 && expected_segments.size() == 0)
         $display("cubic_bezier_flattener_core test passed");
      else begin
         $display("%0d mismatches", mismatches);
         $display("cubic_bezier_flattener_core test failed");
      end
      $finish;
   end
endmodule
